// File: rtl/tmtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_pkg: shared types and constants of the text-mode terminal writer
// Field widths, character codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tmtw_pkg;

  // item field widths
  localparam int unsigned OP_W   = 1;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  // character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the input item
    logic calc_phys;  // logical row to physical row
    logic calc_addr;  // physical row and column to cell address
    logic read_en;    // read cell and row table
    logic write_en;   // write character cell and row fill
    logic advance;    // move cursor after a put
    logic scroll;     // retire top row, blank new bottom row
    logic load_out;   // load result register
  } tmtw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_read;
    logic is_newline;
    logic need_scroll;
  } tmtw_sts_t;

endpackage

// File: rtl/tmtw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_in_if: input item channel
// Valid/ready handshake carrying one put or read request.
// ----------------------------------------------------------------------------
interface tmtw_in_if import tmtw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  read_column;
  logic [ROW_W-1:0]  read_row;

  modport source (output valid, output operation, output char_code,
                  output read_column, output read_row, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input read_column, input read_row, output ready);
endinterface

// File: rtl/tmtw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_out_if: result item channel
// Valid/ready handshake carrying the cell read and the cursor position.
// ----------------------------------------------------------------------------
interface tmtw_out_if import tmtw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic              scrolled;

  modport source (output valid, output cell_value, output cursor_column,
                  output cursor_row, output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_column,
                  input cursor_row, input scrolled, output ready);
endinterface

// File: rtl/tmtw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_ctrl: sequencing state machine
// Steps one item through row mapping, addressing, memory access, an optional
// scroll and the result register; owns the output valid flag.
// ----------------------------------------------------------------------------
module tmtw_ctrl import tmtw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  tmtw_sts_t sts_i,
  output tmtw_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHYS,
    S_ADDR,
    S_ACCESS,
    S_SCROLL,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load_ok;

  // result register free, or being emptied this cycle
  assign load_ok    = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.calc_phys = (state_q == S_PHYS);
    cmd_o.calc_addr = (state_q == S_ADDR);
    cmd_o.read_en   = (state_q == S_ACCESS) && sts_i.op_read;
    cmd_o.write_en  = (state_q == S_ACCESS) && !sts_i.op_read && !sts_i.is_newline;
    cmd_o.advance   = (state_q == S_ACCESS) && !sts_i.op_read;
    cmd_o.scroll    = (state_q == S_SCROLL);
    cmd_o.load_out  = (state_q == S_RESULT) && load_ok;
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a load keeps valid high even when the old item leaves
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PHYS;
          end
        end
        S_PHYS:   state_q <= S_ADDR;
        S_ADDR:   state_q <= S_ACCESS;
        S_ACCESS: begin
          if (!sts_i.op_read && sts_i.need_scroll) begin
            state_q <= S_SCROLL;
          end else begin
            state_q <= S_RESULT;
          end
        end
        S_SCROLL: state_q <= S_RESULT;
        S_RESULT: begin
          if (load_ok) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tmtw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_dp: terminal datapath
// Screen memory addressed through a circular row offset, a per-row table of
// fill count and blank attribute, cursor registers and the result register.
// ----------------------------------------------------------------------------
module tmtw_dp import tmtw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [COL_W-1:0]  read_column_i,
  input  logic [ROW_W-1:0]  read_row_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [COL_W-1:0]  cursor_column_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic              scrolled_o,
  input  tmtw_cmd_t         cmd_i,
  output tmtw_sts_t         sts_o
);

  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned FW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [RW:0]   RowsW   = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] LastRow = RW'(ROWS - 1);
  localparam logic [CW-1:0] LastCol = CW'(COLUMNS - 1);

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  rcol_q;
  logic [ROW_W-1:0]  rrow_q;

  // terminal state
  logic [ATTR_W-1:0] text_color_q;
  logic [CW-1:0]     cur_col_q;
  logic [RW-1:0]     cur_row_q;
  logic [ATTR_W-1:0] cur_attr_q;   // blank attribute of the cursor row
  logic [RW-1:0]     offset_q;     // physical row of logical row 0
  logic [ROWS-1:0]   row_valid_q;
  logic              scrolled_q;

  // work registers
  logic              in_range_q;
  logic [RW-1:0]     phys_q;
  logic [CW-1:0]     col_q;
  logic [AW-1:0]     addr_q;
  logic [CELL_W-1:0] cell_rd_q;
  logic [FW-1:0]     fill_rd_q;
  logic [ATTR_W-1:0] attr_rd_q;
  logic              rv_rd_q;

  // result register
  logic [CELL_W-1:0] out_cell_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_scr_q;

  // memories
  logic [CELL_W-1:0]      cell_mem [CELLS];
  logic [FW+ATTR_W-1:0]   row_mem  [ROWS];

  logic              is_newline;
  logic              col_last;
  logic              row_last;
  logic              wrap;
  logic [RW-1:0]     lrow;
  logic [RW:0]       row_sum;
  logic [RW-1:0]     phys_d;
  logic              rt_we;
  logic [RW-1:0]     rt_waddr;
  logic [FW+ATTR_W-1:0] rt_wdata;
  logic [CELL_W-1:0] cell_d;

  // status
  assign is_newline = (char_q == NEWLINE_CODE);
  assign col_last   = (cur_col_q == LastCol);
  assign row_last   = (cur_row_q == LastRow);
  assign wrap       = is_newline || col_last;

  assign sts_o.op_read     = (op_q == OP_READ);
  assign sts_o.is_newline  = is_newline;
  assign sts_o.need_scroll = wrap && row_last;

  // logical to physical row, one add and one compare-subtract
  assign lrow    = (op_q == OP_READ) ? RW'(rrow_q) : cur_row_q;
  assign row_sum = {1'b0, lrow} + {1'b0, offset_q};
  assign phys_d  = (row_sum >= RowsW) ? RW'(row_sum - RowsW) : RW'(row_sum);

  // row table write port: put updates the fill, scroll blanks the new bottom
  assign rt_we    = cmd_i.write_en || cmd_i.scroll;
  assign rt_waddr = cmd_i.scroll ? offset_q : phys_q;
  assign rt_wdata = cmd_i.scroll ? {{FW{1'b0}}, text_color_q}
                                 : {FW'(cur_col_q) + FW'(1), cur_attr_q};

  // cell seen by a read: stored if written since the row was blanked
  always_comb begin
    cell_d = '0;
    if ((op_q == OP_READ) && in_range_q) begin
      if (rv_rd_q && (FW'(col_q) < fill_rd_q)) begin
        cell_d = cell_rd_q;
      end else begin
        cell_d = {(rv_rd_q ? attr_rd_q : RESET_ATTR), SPACE_CODE};
      end
    end
  end

  // screen memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en) begin
      cell_mem[addr_q] <= {text_color_q, char_q};
    end
    if (cmd_i.read_en) begin
      cell_rd_q <= cell_mem[addr_q];
    end
  end

  // row table memory
  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      row_mem[rt_waddr] <= rt_wdata;
    end
    if (cmd_i.read_en) begin
      {fill_rd_q, attr_rd_q} <= row_mem[phys_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      char_q <= char_code_i;
      rcol_q <= read_column_i;
      rrow_q <= read_row_i;
    end
    if (cmd_i.calc_phys) begin
      in_range_q <= (int'(rcol_q) < COLUMNS) && (int'(rrow_q) < ROWS);
      phys_q     <= phys_d;
      col_q      <= (op_q == OP_READ) ? CW'(rcol_q) : cur_col_q;
    end
    if (cmd_i.calc_addr) begin
      addr_q <= AW'(phys_q) * AW'(COLUMNS) + AW'(col_q);
    end
    if (cmd_i.read_en) begin
      rv_rd_q <= row_valid_q[phys_q];
    end
    if (cmd_i.load_out) begin
      out_cell_q <= cell_d;
      out_col_q  <= COL_W'(cur_col_q);
      out_row_q  <= ROW_W'(cur_row_q);
      out_scr_q  <= scrolled_q;
    end
  end

  // terminal state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_ATTR;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      cur_attr_q   <= RESET_ATTR;
      offset_q     <= '0;
      row_valid_q  <= '0;
      scrolled_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        text_color_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        scrolled_q <= 1'b0;
      end
      if (cmd_i.write_en) begin
        row_valid_q[phys_q] <= 1'b1;
      end
      // cursor step; on the last row the scroll step finishes the move
      if (cmd_i.advance) begin
        cur_col_q <= wrap ? '0 : cur_col_q + CW'(1);
        if (wrap && !row_last) begin
          cur_row_q  <= cur_row_q + RW'(1);
          cur_attr_q <= RESET_ATTR;
        end
      end
      if (cmd_i.scroll) begin
        row_valid_q[offset_q] <= 1'b1;
        offset_q   <= (offset_q == LastRow) ? '0 : offset_q + RW'(1);
        cur_attr_q <= text_color_q;
        scrolled_q <= 1'b1;
      end
    end
  end

  assign cell_value_o    = out_cell_q;
  assign cursor_column_o = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign scrolled_o      = out_scr_q;

endmodule

// File: rtl/text_mode_terminal_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core: text-mode character terminal
// Puts characters at a moving cursor with wrap, newline and scroll, and
// reads back single screen cells.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    operation, char_code, read_column, read_row
//   out_o     out  valid/ready    cell_value, cursor_column, cursor_row,
//                                 scrolled
//   cfg       in   cfg_we_i       cfg_data_i (text colour)
//
// An item runs from acceptance to the next acceptance through row mapping,
// address multiply, one memory access, the scroll step when it scrolls and
// the result load, one after another; the sequencer takes one item at a time.
// Scrolling moves a circular row offset and marks one row blank, so no
// cells are copied. Reset clears per-row valid bits at once; no clearing
// pass. A stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core import tmtw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  tmtw_in_if.sink           in_i,
  tmtw_out_if.source        out_o
);

  tmtw_cmd_t cmd;
  tmtw_sts_t sts;

  // sequencer
  tmtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // screen, cursor and result datapath
  tmtw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (in_i.operation),
    .char_code_i    (in_i.char_code),
    .read_column_i  (in_i.read_column),
    .read_row_i     (in_i.read_row),
    .cell_value_o   (out_o.cell_value),
    .cursor_column_o(out_o.cursor_column),
    .cursor_row_o   (out_o.cursor_row),
    .scrolled_o     (out_o.scrolled),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

`ifndef SYNTHESIS
  // a cell is never read and written in the same step
  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.read_en && cmd.write_en))
    else $error("cell read and write in the same cycle");

  // a scroll only follows a cursor step
  a_scroll_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scroll |-> $past(cmd.advance))
    else $error("scroll without a preceding cursor step");

  // output valid only rises on a result load
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

  // an accepted item closes the input until it is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !in_i.ready)
    else $error("input ready while an item is in work");
`endif

endmodule

// File: sim/tmtw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_checker: screen and cursor scoreboard for the terminal writer
// Watches the config port and both item channels, keeps its own copy of
// the screen, cursor and text colour, predicts the result of every accepted
// item and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module tmtw_checker import tmtw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  tmtw_in_if                in_mon,
  tmtw_out_if               out_mon,
  output int                fail_count_o,
  output int                pending_o,
  output int                scrolls_o,
  output int                reads_o
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } cursor_result_t;

  // predicted terminal state
  logic [CELL_W-1:0] screen_mem [ROWS*COLUMNS];
  logic [ATTR_W-1:0] text_attr;
  int                cur_row;
  int                cur_col;

  cursor_result_t    cursor_results_q [$];
  cursor_result_t    oldest;
  int                fails;
  int                scrolls_seen;
  int                reads_seen;

  // shift every row up by one and blank the bottom row in the current colour
  function automatic void scroll_screen();
    for (int i = 0; i < int'((ROWS - 1) * COLUMNS); i++) begin
      screen_mem[i] = screen_mem[i + COLUMNS];
    end
    for (int c = 0; c < int'(COLUMNS); c++) begin
      screen_mem[(ROWS - 1) * COLUMNS + c] = {text_attr, SPACE_CODE};
    end
    scrolls_seen++;
  endfunction

  // column 0 of the next row, scrolling off the bottom
  function automatic logic move_to_next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= int'(ROWS)) begin
      scroll_screen();
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cursor_result_t predict_terminal_item(
    logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] rc,
    logic [ROW_W-1:0] rr);
    cursor_result_t res;
    res = '0;
    if (op == OP_READ) begin
      reads_seen++;
      // out-of-range reads give zero
      if (int'(rc) < int'(COLUMNS) && int'(rr) < int'(ROWS)) begin
        res.cell_val = screen_mem[int'(rr) * COLUMNS + int'(rc)];
      end
    end else if (ch == NEWLINE_CODE) begin
      res.scrolled = move_to_next_row();
    end else begin
      screen_mem[cur_row * COLUMNS + cur_col] = {text_attr, ch};
      cur_col++;
      if (cur_col >= int'(COLUMNS)) begin
        res.scrolled = move_to_next_row();
      end
    end
    res.col = cur_col[COL_W-1:0];
    res.row = cur_row[ROW_W-1:0];
    return res;
  endfunction

  // compare results, track config, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(ROWS * COLUMNS); i++) begin
        screen_mem[i] = {RESET_ATTR, SPACE_CODE};
      end
      text_attr = RESET_ATTR;
      cur_row = 0;
      cur_col = 0;
      cursor_results_q.delete();
      fails = 0;
      scrolls_seen = 0;
      reads_seen = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      scrolls_o <= 0;
      reads_o <= 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (cursor_results_q.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          oldest = cursor_results_q.pop_front();
          if (out_mon.cell_value !== oldest.cell_val) begin
            $error("cell_value expected %h got %h", oldest.cell_val,
                   out_mon.cell_value);
            fails++;
          end
          if (out_mon.cursor_column !== oldest.col) begin
            $error("cursor_column expected %0d got %0d", oldest.col,
                   out_mon.cursor_column);
            fails++;
          end
          if (out_mon.cursor_row !== oldest.row) begin
            $error("cursor_row expected %0d got %0d", oldest.row, out_mon.cursor_row);
            fails++;
          end
          if (out_mon.scrolled !== oldest.scrolled) begin
            $error("scrolled expected %b got %b", oldest.scrolled, out_mon.scrolled);
            fails++;
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        text_attr = cfg_data_i;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        cursor_results_q.push_back(predict_terminal_item(in_mon.operation,
          in_mon.char_code, in_mon.read_column, in_mon.read_row));
      end
      fail_count_o <= fails;
      pending_o <= cursor_results_q.size();
      scrolls_o <= scrolls_seen;
      reads_o <= reads_seen;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the text-mode terminal writer
// Drives put and read items through colour phases with random idling on
// both channels and one long output stall; the checker predicts and
// compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench import tmtw_pkg::*;;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int          PHASE_SIZE = 360;
  localparam int          CALM_FROM  = 1530;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int scroll_total;
  int read_total;
  int items_sent;
  bit calm;

  tmtw_in_if  in_ch ();
  tmtw_out_if out_ch ();

  text_mode_terminal_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  tmtw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .scrolls_o    (scroll_total),
    .reads_o      (read_total)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall bursts, one long hold-off to back the block up
  initial begin
    int stall_left;
    int taken;
    bit held_off;
    stall_left = 0;
    taken = 0;
    held_off = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) taken++;
      if (!held_off && taken >= 400) begin
        held_off = 1;
        stall_left = 150;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // offer one item and hold it until taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.char_code   <= ch;
    in_ch.read_column <= rc;
    in_ch.read_row    <= rr;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    items_sent++;
  endtask

  // put with random, ignored read coordinates
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, COL_W'($urandom), ROW_W'($urandom));
  endtask

  // read with a random, ignored character
  task automatic read_cell(input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
    send_item(OP_READ, CHAR_W'($urandom), rc, rr);
  endtask

  // drain all results before touching the colour register
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_colour(input logic [ATTR_W-1:0] attr);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= attr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] ch;
    if ($urandom_range(0, 9) == 0) begin
      ch = CHAR_W'($urandom_range(0, 255));
      if (ch == NEWLINE_CODE) ch = 8'h2A;
    end else begin
      ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
    end
    return ch;
  endfunction

  // mostly lines of text, with newline runs, read-backs and raw noise
  task automatic run_random(input int target);
    int kind;
    int len;
    while (items_sent < target) begin
      if (items_sent >= CALM_FROM) calm = 1;
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(81, 170);
          1:       len = $urandom_range(78, 82);
          default: len = $urandom_range(1, 60);
        endcase
        repeat (len) put_char(text_char());
        if ($urandom_range(0, 9) < 7) put_char(NEWLINE_CODE);
      end else if (kind < 62) begin
        repeat ($urandom_range(1, 4)) put_char(NEWLINE_CODE);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 6) == 0) begin
            read_cell(COL_W'($urandom), ROW_W'($urandom));
          end else begin
            read_cell(COL_W'($urandom_range(0, COLUMNS - 1)),
                      ROW_W'($urandom_range(0, ROWS - 1)));
          end
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_item(OP_W'($urandom), CHAR_W'($urandom), COL_W'($urandom),
                    ROW_W'($urandom));
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [ATTR_W-1:0] phase_colours [5];
    phase_colours[0] = 8'hFF;
    phase_colours[1] = 8'h00;
    phase_colours[2] = ATTR_W'($urandom);
    phase_colours[3] = ATTR_W'($urandom);
    phase_colours[4] = 8'h1E;
    items_sent = 0;
    calm = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUT;
    in_ch.char_code = '0;
    in_ch.read_column = '0;
    in_ch.read_row = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes of characters, newline, in and out of range reads
    put_char(8'h48);
    put_char(8'h00);
    put_char(8'hFF);
    send_item(OP_PUT, 8'h7F, 7'h7F, 5'h1F);
    put_char(NEWLINE_CODE);
    put_char(SPACE_CODE);
    put_char(8'h09);
    read_cell(7'd0, 5'd0);
    read_cell(7'd1, 5'd0);
    read_cell(7'd3, 5'd0);
    send_item(OP_READ, 8'hFF, 7'd0, 5'd1);
    send_item(OP_READ, NEWLINE_CODE, 7'd1, 5'd1);
    read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
    read_cell(7'(COLUMNS), 5'd0);
    read_cell(7'd0, 5'(ROWS));
    read_cell(7'h7F, 5'h1F);
    put_char(NEWLINE_CODE);
    put_char(NEWLINE_CODE);
    put_char(8'h41);
    read_cell(7'd0, 5'd3);

    // random phases, each under its own text colour
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_colour(phase_colours[p]);
      run_random((p + 1) * PHASE_SIZE);
    end

    wait_idle();
    $display("Ran %0d items over 6 colour settings: %0d screen scrolls, %0d cell reads",
             items_sent, scroll_total, read_total);
    $display("Cursor wrap, newline, scroll blanking and out-of-range reads included");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
